/* hw/rtl/cwsh_pkg.sv */
package cwsh_pkg;

    localparam int RADIUS     = 3;
    localparam int MAX_WIDTH  = 256;
    localparam int WIN        = 2 * RADIUS + 1;
    localparam int CELLS      = WIN * WIN;
    localparam int DEPTH      = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int AW         = $clog2(DEPTH);
    localparam int FW         = $clog2(DEPTH + 1);
    localparam int WB         = $clog2(MAX_WIDTH + 1);
    localparam int IW         = $clog2(WIN);
    localparam int CW         = $clog2(CELLS + 1);
    localparam int SW         = 16 + CW;
    localparam int DCW        = $clog2(SW);
    localparam int SQ_W       = $clog2(2 * RADIUS * RADIUS + 1);
    localparam int CCW        = $clog2((RADIUS + 1) * MAX_WIDTH);
    localparam int CSW        = CCW + 1;
    localparam int CMP_W      = 8;
    localparam int REACH_W    = 5;
    localparam int MWIDTH_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REACH_SQ  = 2'd0,
        CFG_MAP_WIDTH = 2'd1,
        CFG_USE_MEAN  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              action;
        logic signed [15:0] height;
        logic              known;
    } t_in_item;

    typedef struct packed {
        logic [15:0] step_height;
        logic        has_value;
    } t_out_item;

    typedef struct packed {
        logic        in_map;
        logic        known;
        logic [15:0] height;
    } t_entry;

    typedef struct packed {
        logic          wr;
        t_entry        wdata;
        logic          rd;
        logic [AW-1:0] back;
    } t_store_req;

    typedef struct packed {
        logic        used;
        logic [15:0] val;
    } t_cell_data;

    typedef struct packed {
        logic shift;
        logic comp;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CCOL,
        S_CTR,
        S_CWAIT,
        S_LOAD,
        S_LAST,
        S_COMP,
        S_DRAIN,
        S_DSTART,
        S_DIV,
        S_DONE
    } t_state;

    function automatic logic [SQ_W-1:0] off_sq(logic [IW-1:0] i, logic [IW-1:0] j);
        logic [IW-1:0]   dx;
        logic [IW-1:0]   dy;
        logic [SQ_W-1:0] a;
        logic [SQ_W-1:0] b;
        dx = (i >= IW'(RADIUS)) ? i - IW'(RADIUS) : IW'(RADIUS) - i;
        dy = (j >= IW'(RADIUS)) ? j - IW'(RADIUS) : IW'(RADIUS) - j;
        a  = SQ_W'(dx);
        b  = SQ_W'(dy);
        return a * a + b * b;
    endfunction

endpackage

/* hw/rtl/circular_window_step_height.sv */
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time; a center outside the map or an unknown center ends the item early.
// The 49 window reads go through the single read port of the row store, then the
// 49-cell chain drains into one accumulator; the mean adds a bit-serial divider.
// Reset (synchronous, active low) empties the row store through its fill count.
// A result waiting on o_out_item does not block the next item from being taken.
module circular_window_step_height (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cwsh_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cwsh_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cwsh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cwsh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cwsh_pkg::t_state                 r_state;
    cwsh_pkg::t_state                 n_state;
    logic [cwsh_pkg::REACH_W-1:0]     r_reach;
    logic [cwsh_pkg::MWIDTH_W-1:0]    r_map_width;
    logic                             r_use_mean;
    logic [cwsh_pkg::WB-1:0]          w_eff;
    logic [cwsh_pkg::WB-1:0]          r_w;
    logic [cwsh_pkg::WB-1:0]          r_col;
    logic [cwsh_pkg::WB-1:0]          col0;
    logic [cwsh_pkg::WB-1:0]          col1;
    logic [cwsh_pkg::CCW-1:0]         r_ccol;
    logic [cwsh_pkg::IW-1:0]          r_i;
    logic [cwsh_pkg::IW-1:0]          r_j;
    logic [cwsh_pkg::AW-1:0]          r_rb;
    logic                             r_pvld;
    logic                             r_pflag;
    logic [15:0]                      r_ch;
    logic [cwsh_pkg::CW-1:0]          r_k;
    logic [cwsh_pkg::CW-1:0]          r_cnt;
    logic [cwsh_pkg::SW-1:0]          r_sum;
    logic [15:0]                      r_max;
    cwsh_pkg::t_out_item              r_res;
    cwsh_pkg::t_out_item              r_out;
    logic                             r_out_valid;
    logic                             in_acc;
    logic                             out_load;
    logic                             flag;
    logic [cwsh_pkg::CSW-1:0]         col_sum;
    logic                             last_ij;
    cwsh_pkg::t_store_req             store_req;
    cwsh_pkg::t_entry                 rd_entry;
    cwsh_pkg::t_cell_ctl              cell_ctl;
    cwsh_pkg::t_cell_data             chain [cwsh_pkg::CELLS+1];
    cwsh_pkg::t_cell_data             tail;
    logic                             div_start;
    logic                             div_done;
    logic [cwsh_pkg::SW-1:0]          div_quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach     <= cwsh_pkg::REACH_W'(9);
            r_map_width <= cwsh_pkg::MWIDTH_W'(256);
            r_use_mean  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cwsh_pkg::t_cfg_idx'(i_cfg_index))
                cwsh_pkg::CFG_REACH_SQ:  r_reach     <= i_cfg_data[cwsh_pkg::REACH_W-1:0];
                cwsh_pkg::CFG_MAP_WIDTH: r_map_width <= i_cfg_data[cwsh_pkg::MWIDTH_W-1:0];
                cwsh_pkg::CFG_USE_MEAN:  r_use_mean  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = cwsh_pkg::WB'(1);
        end else if (int'(r_map_width) > cwsh_pkg::MAX_WIDTH) begin
            w_eff = cwsh_pkg::WB'(cwsh_pkg::MAX_WIDTH);
        end else begin
            w_eff = cwsh_pkg::WB'(r_map_width);
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == cwsh_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign col0     = (r_col >= w_eff) ? '0 : r_col;
    assign col1     = (col0 + 1'b1 >= w_eff) ? '0 : col0 + 1'b1;

    assign col_sum = cwsh_pkg::CSW'(r_ccol) + cwsh_pkg::CSW'(r_i);
    assign flag    = (cwsh_pkg::CMP_W'(cwsh_pkg::off_sq(r_i, r_j))
                      <= cwsh_pkg::CMP_W'(r_reach))
                  && (col_sum >= cwsh_pkg::CSW'(cwsh_pkg::RADIUS))
                  && (col_sum < cwsh_pkg::CSW'(r_w) + cwsh_pkg::CSW'(cwsh_pkg::RADIUS));
    assign last_ij = (r_i == cwsh_pkg::IW'(cwsh_pkg::WIN - 1))
                  && (r_j == cwsh_pkg::IW'(cwsh_pkg::WIN - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwsh_pkg::S_IDLE:  if (in_acc) n_state = cwsh_pkg::S_CCOL;
            cwsh_pkg::S_CCOL:  if (r_ccol < cwsh_pkg::CCW'(r_w)) n_state = cwsh_pkg::S_CTR;
            cwsh_pkg::S_CTR:   n_state = cwsh_pkg::S_CWAIT;
            cwsh_pkg::S_CWAIT: begin
                if (!rd_entry.in_map) begin
                    n_state = cwsh_pkg::S_IDLE;
                end else if (!rd_entry.known) begin
                    n_state = cwsh_pkg::S_DONE;
                end else begin
                    n_state = cwsh_pkg::S_LOAD;
                end
            end
            cwsh_pkg::S_LOAD:  if (last_ij) n_state = cwsh_pkg::S_LAST;
            cwsh_pkg::S_LAST:  n_state = cwsh_pkg::S_COMP;
            cwsh_pkg::S_COMP:  n_state = cwsh_pkg::S_DRAIN;
            cwsh_pkg::S_DRAIN: begin
                if (r_k == cwsh_pkg::CW'(cwsh_pkg::CELLS - 1)) n_state = cwsh_pkg::S_DSTART;
            end
            cwsh_pkg::S_DSTART: begin
                if (r_cnt != '0 && r_use_mean) begin
                    n_state = cwsh_pkg::S_DIV;
                end else begin
                    n_state = cwsh_pkg::S_DONE;
                end
            end
            cwsh_pkg::S_DIV:   if (div_done) n_state = cwsh_pkg::S_DONE;
            cwsh_pkg::S_DONE:  if (out_load) n_state = cwsh_pkg::S_IDLE;
            default:           n_state = cwsh_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != cwsh_pkg::S_IDLE);
        store_req.wr      = in_acc;
        store_req.wdata   = i_in_item.action ? '0
                          : {1'b1, i_in_item.known, i_in_item.height};
        store_req.rd      = 1'b0;
        store_req.back    = '0;
        cell_ctl.shift    = r_pvld || (r_state == cwsh_pkg::S_DRAIN);
        cell_ctl.comp     = (r_state == cwsh_pkg::S_COMP);
        div_start         = (r_state == cwsh_pkg::S_DSTART) && (r_cnt != '0) && r_use_mean;
        unique case (r_state)
            cwsh_pkg::S_CTR: begin
                store_req.rd   = 1'b1;
                store_req.back = cwsh_pkg::AW'(r_w) * cwsh_pkg::AW'(cwsh_pkg::RADIUS)
                               + cwsh_pkg::AW'(cwsh_pkg::RADIUS);
            end
            cwsh_pkg::S_LOAD: begin
                store_req.rd   = 1'b1;
                store_req.back = r_rb
                               + cwsh_pkg::AW'(cwsh_pkg::IW'(2 * cwsh_pkg::RADIUS) - r_i);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwsh_pkg::S_IDLE;
            r_col       <= '0;
            r_pvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= (r_state == cwsh_pkg::S_LOAD);
            if (in_acc) begin
                r_col <= col1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pflag <= flag;
        if (out_load) begin
            r_out <= r_res;
        end
        unique case (r_state)
            cwsh_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_w    <= w_eff;
                    r_ccol <= cwsh_pkg::CCW'(col0)
                            + cwsh_pkg::CCW'(w_eff) * cwsh_pkg::CCW'(cwsh_pkg::RADIUS)
                            - cwsh_pkg::CCW'(cwsh_pkg::RADIUS);
                end
            end
            cwsh_pkg::S_CCOL: begin
                if (r_ccol >= cwsh_pkg::CCW'(r_w)) begin
                    r_ccol <= r_ccol - cwsh_pkg::CCW'(r_w);
                end
            end
            cwsh_pkg::S_CWAIT: begin
                r_res <= '0;
                r_ch  <= rd_entry.height;
                r_i   <= '0;
                r_j   <= '0;
                r_rb  <= cwsh_pkg::AW'(r_w) * cwsh_pkg::AW'(2 * cwsh_pkg::RADIUS);
            end
            cwsh_pkg::S_LOAD: begin
                if (r_i == cwsh_pkg::IW'(cwsh_pkg::WIN - 1)) begin
                    r_i  <= '0;
                    r_j  <= r_j + 1'b1;
                    r_rb <= r_rb - cwsh_pkg::AW'(r_w);
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            cwsh_pkg::S_COMP: begin
                r_k   <= '0;
                r_cnt <= '0;
                r_sum <= '0;
                r_max <= '0;
            end
            cwsh_pkg::S_DRAIN: begin
                r_k <= r_k + 1'b1;
                if (tail.used) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sum <= r_sum + cwsh_pkg::SW'(tail.val);
                    if (tail.val > r_max) begin
                        r_max <= tail.val;
                    end
                end
            end
            cwsh_pkg::S_DSTART: begin
                if (r_cnt == '0) begin
                    r_res <= '0;
                end else begin
                    r_res <= {r_max, 1'b1};
                end
            end
            cwsh_pkg::S_DIV: begin
                if (div_done) begin
                    r_res <= {div_quot[15:0], 1'b1};
                end
            end
            default: ;
        endcase
    end

    cwsh_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_entry (rd_entry)
    );

    assign chain[0] = r_pvld
                    ? {r_pflag && rd_entry.in_map && rd_entry.known, rd_entry.height}
                    : '0;

    for (genvar k = 0; k < cwsh_pkg::CELLS; k++) begin : g_cell
        cwsh_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_prev   (chain[k]),
            .i_center (r_ch),
            .o_data   (chain[k+1])
        );
    end

    assign tail = chain[cwsh_pkg::CELLS];

    cwsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == cwsh_pkg::S_CCOL)
        else $error("accepted item did not start the center column step");
    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwsh_pkg::S_DIV && div_done) |=> r_state == cwsh_pkg::S_DONE)
        else $error("divider result not taken");
    a_ccol_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cwsh_pkg::S_LOAD |-> r_ccol < cwsh_pkg::CCW'(r_w))
        else $error("center column not reduced below width");
`endif

endmodule

/* hw/rtl/cwsh_store.sv */
module cwsh_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cwsh_pkg::t_store_req   i_req,
    output cwsh_pkg::t_entry       o_rd_entry
);

    cwsh_pkg::t_entry                mem [cwsh_pkg::DEPTH];
    cwsh_pkg::t_entry                r_rd_data;
    logic                            r_rd_ok;
    logic [cwsh_pkg::AW-1:0]         r_pos;
    logic [cwsh_pkg::AW-1:0]         n_pos;
    logic [cwsh_pkg::FW-1:0]         r_fill;
    logic [cwsh_pkg::AW-1:0]         rd_addr;

    assign n_pos = (r_pos == cwsh_pkg::AW'(cwsh_pkg::DEPTH - 1)) ? '0 : r_pos + 1'b1;

    assign rd_addr = (r_pos >= i_req.back) ? r_pos - i_req.back
                   : r_pos + cwsh_pkg::AW'(cwsh_pkg::DEPTH) - i_req.back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= i_req.rd && (cwsh_pkg::FW'(i_req.back) < r_fill);
            if (i_req.wr) begin
                r_pos <= n_pos;
                if (r_fill != cwsh_pkg::FW'(cwsh_pkg::DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            mem[n_pos] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_rd_entry = r_rd_ok ? r_rd_data : '0;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < cwsh_pkg::AW'(cwsh_pkg::DEPTH))
        else $error("store position out of range");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= cwsh_pkg::FW'(cwsh_pkg::DEPTH))
        else $error("fill count out of range");
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.wr && r_fill < cwsh_pkg::FW'(cwsh_pkg::DEPTH)) |=> r_fill == $past(r_fill) + 1'b1)
        else $error("fill count did not follow write");
`endif

endmodule

/* hw/rtl/cwsh_cell.sv */
module cwsh_cell (
    input  logic                   i_clk,
    input  cwsh_pkg::t_cell_ctl    i_ctl,
    input  cwsh_pkg::t_cell_data   i_prev,
    input  logic [15:0]            i_center,
    output cwsh_pkg::t_cell_data   o_data
);

    cwsh_pkg::t_cell_data r_data;
    logic [16:0]          diff;
    logic [16:0]          mag;

    assign diff = {r_data.val[15], r_data.val} - {i_center[15], i_center};
    assign mag  = diff[16] ? (~diff + 17'd1) : diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_prev;
        end else if (i_ctl.comp) begin
            r_data.val <= mag[15:0];
        end
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/cwsh_div.sv */
module cwsh_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [cwsh_pkg::SW-1:0] i_num,
    input  logic [cwsh_pkg::CW-1:0] i_den,
    output logic                    o_done,
    output logic [cwsh_pkg::SW-1:0] o_quot
);

    logic                     r_busy;
    logic                     r_done;
    logic [cwsh_pkg::DCW-1:0] r_cnt;
    logic [cwsh_pkg::SW-1:0]  r_q;
    logic [cwsh_pkg::CW-1:0]  r_rem;
    logic [cwsh_pkg::CW-1:0]  r_den;
    logic [cwsh_pkg::CW:0]    trial;
    logic [cwsh_pkg::CW:0]    t_sub;
    logic                     ge;
    logic [cwsh_pkg::CW-1:0]  n_rem;

    assign trial = {r_rem, r_q[cwsh_pkg::SW-1]};
    assign t_sub = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? t_sub[cwsh_pkg::CW-1:0] : trial[cwsh_pkg::CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == cwsh_pkg::DCW'(cwsh_pkg::SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[cwsh_pkg::SW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
